### hw/rtl/tilt_compensated_heading_assert.svh
// Assertion shorthands for the heading datapath.
// Both sample on clk and stay quiet while rst is high.
`ifndef TILT_COMPENSATED_HEADING_ASSERT_SVH
`define TILT_COMPENSATED_HEADING_ASSERT_SVH

// Same-cycle implication.
`define TCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tch assertion failed");

// Next-cycle implication.
`define TCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tch assertion failed");

`endif

### hw/rtl/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tch_pkg;

  localparam int TAB_LEN = 24;
  localparam int XW      = 36;   // CORDIC x/y datapath width
  localparam int ZW      = 34;   // CORDIC angle accumulator width

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic signed [XW-1:0] CORDIC_K = XW'(652032874);

  // centidegrees to binary angle: 2^32/36000 = 2^27/1125 = Q_INT + Q_FRAC/1125
  localparam logic [16:0] Q_INT  = 17'd119304;
  localparam logic [9:0]  Q_FRAC = 10'd728;
  localparam logic [25:0] RECIP_1125 = 26'd61083980;   // ceil(2^36/1125)
  localparam int          RECIP_SHIFT = 36;

  localparam logic [15:0] FULL_CD = 16'd36000;
  localparam logic signed [15:0] HALF_CD = 16'sd18000;

  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/tilt_compensated_heading.sv
// Throughput: one word per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so stalls come only from out_ready.
// Reset: synchronous rst clears all valid bits and sets declination to 0.
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// Tilt-compensated compass heading: sin/cos CORDIC, horizontal projection,
// atan2 CORDIC, centidegree conversion with declination and wrap.
// ----------------------------------------------------------------------------
module tilt_compensated_heading
  import tch_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  input  logic signed [15:0] roll,
  input  logic signed [15:0] pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        heading,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] declination
);

`include "tilt_compensated_heading_assert.svh"

  localparam int N     = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int MDLY  = N + 3;

  logic en;
  logic signed [15:0] decl;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decl <= '0;
    end else if (cfg_valid) begin
      decl <= declination;
    end
  end

  // magnetometer words ride alongside the angle path
  logic [47:0] md [0:MDLY-1];
  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= {mag_x, mag_y, mag_z};
      for (int k = 1; k < MDLY; k++) begin
        md[k] <= md[k-1];
      end
    end
  end

  // angle front end: index 0 roll, index 1 pitch
  logic signed [15:0] ang_in [0:1];
  assign ang_in[0] = roll;
  assign ang_in[1] = pitch;

  logic va, vb, vp;
  logic signed [XW-1:0] cs_x [0:1];
  logic signed [XW-1:0] cs_y [0:1];
  logic                 cs_v [0:1];

  for (genvar j = 0; j < 2; j++) begin : g_ang
    logic [15:0] mag;
    logic [32:0] p_int;
    logic [25:0] p_frac;
    logic        neg_a;
    logic [51:0] qq_full;
    logic [32:0] q;
    logic [31:0] bam, bam_q, bam_rot;
    logic        flip;
    logic signed [XW-1:0] x0;
    logic signed [ZW-1:0] z0;
    logic signed [ZW-1:0] z_unused;

    assign mag = ang_in[j][15] ? 16'(-ang_in[j]) : ang_in[j];

    // stage A: split the scale into integer and fractional products
    always_ff @(posedge clk) begin
      if (en) begin
        p_int  <= 33'(17'(mag) * Q_INT);
        p_frac <= 26'(mag) * 26'(Q_FRAC);
        neg_a  <= ang_in[j][15];
      end
    end

    // stage B: divide the fraction by 1125, truncate toward zero
    assign qq_full = 52'(p_frac) * 52'(RECIP_1125);
    assign q       = p_int + 33'(qq_full >> RECIP_SHIFT);
    assign bam     = neg_a ? 32'(-q[31:0]) : q[31:0];

    always_ff @(posedge clk) begin
      if (en) begin
        bam_q <= bam;
      end
    end

    // stage P: fold the left half plane onto the right
    assign flip    = bam_q[31] ^ bam_q[30];
    assign bam_rot = flip ? bam_q - HALF_TURN : bam_q;

    always_ff @(posedge clk) begin
      if (en) begin
        x0 <= flip ? -CORDIC_K : CORDIC_K;
        z0 <= ZW'(signed'(bam_rot));
      end
    end

    tch_cordic #(.STAGES(N), .VECTORING(1'b0)) u_sincos (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vp),
      .x_in     (x0),
      .y_in     ('0),
      .z_in     (z0),
      .out_valid(cs_v[j]),
      .x_out    (cs_x[j]),
      .y_out    (cs_y[j]),
      .z_out    (z_unused)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vp <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vp <= vb;
    end
  end

  // projection into the horizontal plane
  logic signed [31:0] cr, sr, cp, sp;
  logic signed [15:0] mx, my, mz;
  assign cr = cs_x[0][31:0];
  assign sr = cs_y[0][31:0];
  assign cp = cs_x[1][31:0];
  assign sp = cs_y[1][31:0];
  assign mx = md[MDLY-1][47:32];
  assign my = md[MDLY-1][31:16];
  assign mz = md[MDLY-1][15:0];

  logic v1, v2, v3, v4, vv;
  logic signed [47:0] p_ysr, p_zcr, p_ycr, p_zsr, p_xcp;
  logic signed [31:0] sp1, sp2;
  logic signed [33:0] t2, xa2, yh2, xa3, yh3, xh4, yh4;
  logic signed [63:0] p_tsp;
  logic signed [48:0] sum_t, sum_y;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ysr <= 48'(my) * 48'(sr);
      p_zcr <= 48'(mz) * 48'(cr);
      p_ycr <= 48'(my) * 48'(cr);
      p_zsr <= 48'(mz) * 48'(sr);
      p_xcp <= 48'(mx) * 48'(cp);
      sp1   <= sp;
    end
  end

  assign sum_t = 49'(p_ysr) + 49'(p_zcr);
  assign sum_y = 49'(p_ycr) - 49'(p_zsr);

  always_ff @(posedge clk) begin
    if (en) begin
      t2  <= 34'(sum_t >>> 15);
      yh2 <= 34'(sum_y >>> 15);
      xa2 <= 34'(p_xcp >>> 15);
      sp2 <= sp1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_tsp <= 64'(t2) * 64'(sp2);
      xa3   <= xa2;
      yh3   <= yh2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xh4 <= xa3 + 34'(p_tsp >>> 30);
      yh4 <= yh3;
    end
  end

  // vectoring entry: mirror into the right half plane
  logic signed [XW-1:0] vx0, vy0;
  logic signed [ZW-1:0] vz0;
  logic                 zero_v;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_v <= (xh4 == '0) && (yh4 == '0);
      if (xh4[33]) begin
        vx0 <= -XW'(xh4);
        vy0 <= -XW'(yh4);
        vz0 <= ZW'({1'b0, HALF_TURN});
      end else begin
        vx0 <= XW'(xh4);
        vy0 <= XW'(yh4);
        vz0 <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vv <= 1'b0;
    end else if (en) begin
      v1 <= cs_v[0];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vv <= v4;
    end
  end

  logic zd [0:N-1];
  always_ff @(posedge clk) begin
    if (en) begin
      zd[0] <= zero_v;
      for (int k = 1; k < N; k++) begin
        zd[k] <= zd[k-1];
      end
    end
  end

  logic                 va2_v;
  logic signed [XW-1:0] va_x, va_y;
  logic signed [ZW-1:0] va_z;

  tch_cordic #(.STAGES(N), .VECTORING(1'b1)) u_atan2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vv),
    .x_in     (vx0),
    .y_in     (vy0),
    .z_in     (vz0),
    .out_valid(va2_v),
    .x_out    (va_x),
    .y_out    (va_y),
    .z_out    (va_z)
  );

  // binary angle to centidegrees, declination, wrap
  logic               vc1;
  logic signed [31:0] sang;
  logic signed [47:0] pc;
  logic signed [47:0] pc_rnd;
  logic signed [15:0] cd_raw, cd;
  logic signed [17:0] h0, h1;
  logic [15:0]        heading_next;

  assign sang = zd[N-1] ? '0 : signed'(va_z[31:0]);

  always_ff @(posedge clk) begin
    if (en) begin
      pc <= 48'(sang) * 48'sd36000;
    end
  end

  always_comb begin
    pc_rnd = pc + 48'sh0000_8000_0000;
    cd_raw = pc_rnd[47:32];
    cd     = (cd_raw == -HALF_CD) ? HALF_CD : cd_raw;
    h0     = 18'(cd) + 18'(decl);
    if (h0 < 0) begin
      h1 = h0 + 18'sd36000;
    end else if (h0 > 18'sd36000) begin
      h1 = h0 - 18'sd36000;
    end else begin
      h1 = h0;
    end
    // clamp what a single wrap cannot reach
    if (h1 < 0) begin
      heading_next = '0;
    end else if (h1 > 18'sd36000) begin
      heading_next = FULL_CD;
    end else begin
      heading_next = h1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc1       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vc1       <= va2_v;
      out_valid <= vc1;
    end
    if (en) begin
      heading <= heading_next;
    end
  end

  `TCH_ASSERT_IMP(a_heading_range, out_valid, heading <= FULL_CD)
  `TCH_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
  `TCH_ASSERT_NXT(a_cfg_write, cfg_valid, decl == $past(declination))

endmodule

### hw/rtl/tch_cordic.sv
// ----------------------------------------------------------------------------
// tch_cordic
// Pipelined CORDIC, one micro-rotation per register stage; rotation or
// vectoring mode.
// ----------------------------------------------------------------------------
module tch_cordic
  import tch_pkg::*;
#(
  parameter int STAGES    = 16,
  parameter bit VECTORING = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic                 out_valid,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic                 vs [0:STAGES];
  logic signed [XW-1:0] xs [0:STAGES];
  logic signed [XW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0] zs [0:STAGES];

  assign vs[0] = in_valid;
  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    logic                 dir;

    assign dx  = ys[i] >>> i;
    assign dy  = xs[i] >>> i;
    assign da  = signed'({{(ZW-32){1'b0}}, atan_tab(5'(i))});
    // vectoring drives y toward zero, rotation drives z toward zero
    assign dir = VECTORING ? ys[i][XW-1] : !zs[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        if (dir) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
      end
    end
  end

  assign out_valid = vs[STAGES];
  assign x_out     = xs[STAGES];
  assign y_out     = ys[STAGES];
  assign z_out     = zs[STAGES];

endmodule

### dv/tilt_compensated_heading_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_heading_tb
// Drives magnetometer samples with roll and pitch, predicts each heading with
// a bit-exact CORDIC model and checks every output word in order.
// ----------------------------------------------------------------------------
module tilt_compensated_heading_tb;
  import tch_pkg::*;

  localparam int STAGES  = 16;
  localparam int NSTG    = (STAGES > TAB_LEN) ? TAB_LEN : STAGES;
  localparam int LATENCY = 2 * NSTG + 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] mag_x = '0, mag_y = '0, mag_z = '0, roll = '0, pitch = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        heading;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [15:0] declination = '0;

  logic signed [15:0] decl_model;
  logic [15:0]        heading_q[$];
  int                 errors = 0;
  bit                 rx_enable = 1'b0;

  tilt_compensated_heading #(.CORDIC_STAGES(STAGES)) uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] cd_to_angle(longint cd);
    longint q;
    q = (cd * 64'sd4294967296) / 36000;
    return q[31:0];
  endfunction

  function automatic longint atan_val(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  task automatic rotate_sincos(input logic [31:0] a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [31:0] tq;
    x = 652032874; y = 0;
    tq = a + QUARTER_TURN;
    if (tq[31]) begin
      x = -x;
      a = a - HALF_TURN;
    end
    z = longint'($signed(a));
    for (int i = 0; i < NSTG; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    c = x; s = y;
  endtask

  function automatic logic [31:0] vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sh8000_0000;
    end
    for (int i = 0; i < NSTG; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_val(i);
      end else begin
        x += dx; y -= dy; z += atan_val(i);
      end
    end
    return z[31:0];
  endfunction

  task automatic predict_heading(input logic signed [15:0] mx, my, mz, r, p,
                                 output logic [15:0] h_out);
    longint cr, sr, cp, sp, t, xh, yh, cd, h;
    logic [31:0] ang;
    rotate_sincos(cd_to_angle(r), cr, sr);
    rotate_sincos(cd_to_angle(p), cp, sp);
    t  = floor_shr(my * sr + mz * cr, 15);
    xh = floor_shr(mx * cp, 15) + floor_shr(t * sp, 30);
    yh = floor_shr(my * cr - mz * sr, 15);
    ang = vector_angle(yh, xh);
    cd = floor_shr(longint'($signed(ang)) * 36000 + 64'sh8000_0000, 32);
    if (cd == -18000) cd = 18000;
    h = cd + decl_model;
    if (h < 0) h += 36000;
    else if (h > 36000) h -= 36000;
    if (h < 0) h = 0;
    if (h > 36000) h = 36000;
    h_out = h[15:0];
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Output side: random stalls, compare each word with the oldest prediction.
  initial begin
    int gap;
    @(negedge clk);
    while (!rx_enable) @(negedge clk);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (heading_q.size() == 0)
        report_mismatch($sformatf("unexpected heading %0d", heading));
      else begin
        if (heading !== heading_q[0])
          report_mismatch($sformatf("heading %0d, expected %0d", heading, heading_q[0]));
        void'(heading_q.pop_front());
      end
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic signed [15:0] mx, my, mz, r, p, input bit nogap);
    logic [15:0] h;
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mag_x <= mx; mag_y <= my; mag_z <= mz; roll <= r; pitch <= p;
    predict_heading(mx, my, mz, r, p, h);
    do @(posedge clk); while (!in_ready);
    heading_q.push_back(h);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (heading_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_declination(input logic signed [15:0] d);
    cfg_valid <= 1'b1;
    declination <= d;
    do @(posedge clk); while (!cfg_ready);
    decl_model = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $signed(16'($urandom));
      1: return 16'(int'($urandom_range(0, 72000)) - 36000);
      default: return 16'(int'($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  task automatic test_directed;
    logic signed [15:0] ex[5] = '{16'sh8000, 16'sh7fff, 16'sd0, 16'sd1, -16'sd1};
    logic signed [15:0] an[6] = '{-16'sd18000, 16'sd18000, 16'sd0, 16'sd9000,
                                  -16'sd9000, 16'sh7fff};
    write_declination(16'sd0);
    send_sample(0, 0, 0, 0, 0, 1'b0);
    for (int i = 0; i < 5; i++)
      send_sample(ex[i], ex[(i+1)%5], ex[(i+2)%5], an[i], an[i+1], 1'b0);
    send_sample(-16'sd1000, 16'sd0, 16'sd0, 0, 0, 1'b0);
    send_sample(-16'sd1000, -16'sd1, 16'sd0, 0, 0, 1'b0);
    send_sample(16'sd0, 16'sd1000, 16'sd500, 16'sh8000, 16'sh8000, 1'b0);
    drain();
  endtask

  task automatic test_declination_extremes;
    logic signed [15:0] dv[6] = '{16'sd18000, -16'sd18000, 16'sh7fff, 16'sh8000,
                                  16'sd1234, -16'sd1};
    foreach (dv[k]) begin
      write_declination(dv[k]);
      for (int i = 0; i < 4; i++)
        send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                    rand_angle(), rand_angle(), 1'b0);
      drain();
    end
  endtask

  task automatic test_random(input int n);
    bit burst;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        drain();
        write_declination(16'(int'($urandom_range(0, 36000)) - 18000));
      end
      burst = (i % 100) < 20;
      send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                  rand_angle(), rand_angle(), burst);
    end
    drain();
  endtask

  initial begin
    decl_model = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rx_enable = 1'b1;
    test_directed();
    test_declination_extremes();
    test_random(1000);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### tilt_compensated_heading.f
+incdir+hw/rtl
hw/rtl/tch_pkg.sv
hw/rtl/tch_cordic.sv
hw/rtl/tilt_compensated_heading.sv
dv/tilt_compensated_heading_tb.sv
